/* rtl/core/asd_pkg.sv */
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants of the accelerometer shake detector: control
// state, per-axis datapath controls and configuration register codes.
// ----------------------------------------------------------------------------
package asd_pkg;

    // digit width of the serial multiply and square units
    localparam int DIG        = 4;
    localparam int ALPHA_BITS = 16;
    localparam int MUL_STEPS  = ALPHA_BITS / DIG;
    localparam int NUM_AXES   = 3;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int TIME_BITS  = 32;

    localparam int ENERGY_BITS = 34;
    localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;

    localparam logic [CFG_BITS-1:0] THRESHOLD_RST = 16'd600;
    localparam logic [CFG_BITS-1:0] HOLDOFF_RST   = 16'd500;
    localparam logic [CFG_BITS-1:0] ALPHA_RST     = 16'd1311;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_HOLDOFF   = 2'd1,
        CFG_ALPHA     = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DEV,
        ST_SQI,
        ST_SQ,
        ST_SUM,
        ST_CMP
    } t_state;

    typedef struct packed {
        logic init;   // start request: load baseline from sample
        logic load;   // capture sample and form sample - baseline
        logic mul;    // one alpha digit of the baseline update
        logic rnd;    // last alpha digit, adds the rounding half
        logic upd;    // baseline += update
        logic dev;    // rounded deviation from the new baseline
        logic sqi;    // load magnitude into the square unit
        logic sq;     // one digit of the square
    } t_axis_ctl;

endpackage

/* rtl/core/asd_axis.sv */
// ----------------------------------------------------------------------------
// asd_axis
// One axis lane: baseline filter with a digit-serial alpha multiply, rounded
// deviation and a digit-serial square of its magnitude.
// ----------------------------------------------------------------------------
module asd_axis #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  asd_pkg::t_axis_ctl                  i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic [asd_pkg::ALPHA_BITS-1:0]      i_alpha,
    output logic [2*SAMPLE_BITS-1:0]            o_square
);
    import asd_pkg::*;

    localparam int BW = SAMPLE_BITS + FRAC_BITS;   // baseline
    localparam int DW = BW + 1;                     // difference
    localparam int AW = DW + 1;                     // update accumulator
    localparam int PW = AW + DIG + 1;               // accumulator sum
    localparam int SQ_STEPS = (SAMPLE_BITS + DIG - 1) / DIG;
    localparam int MW = SQ_STEPS * DIG;
    localparam int HW = SAMPLE_BITS + DIG;
    localparam int FW = SAMPLE_BITS + MW;
    localparam logic signed [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] RND  = PW'(1) << (DIG - 1);

    logic signed [BW-1:0]          r_base;
    logic signed [SAMPLE_BITS-1:0] r_samp;
    logic signed [DW-1:0]          r_diff;
    logic [ALPHA_BITS-1:0]         r_alpha_sh;
    logic signed [AW-1:0]          r_acc;
    logic signed [SAMPLE_BITS:0]   r_di;
    logic [SAMPLE_BITS-1:0]        r_mag;
    logic [MW-1:0]                 r_msh;
    logic [SAMPLE_BITS-1:0]        r_hi;
    logic [MW-1:0]                 r_lo;

    logic signed [BW-1:0]  w_in_scaled;
    logic signed [BW-1:0]  w_s_scaled;
    logic signed [DIG:0]   w_digit;
    logic signed [PW-1:0]  w_prod;
    logic signed [PW-1:0]  w_sum;
    logic signed [PW-1:0]  w_shift;
    logic signed [DW-1:0]  w_dev;
    logic [SAMPLE_BITS:0]  w_mag;
    logic [HW-1:0]         w_pp;
    logic [HW-1:0]         w_sq_sum;
    logic [FW-1:0]         w_full;

    assign w_in_scaled = {i_sample, {FRAC_BITS{1'b0}}};
    assign w_s_scaled  = {r_samp, {FRAC_BITS{1'b0}}};

    // right-shifting digit multiply, floor at each step keeps it exact
    assign w_digit = {1'b0, r_alpha_sh[DIG-1:0]};
    assign w_prod  = PW'(r_diff) * PW'(w_digit);
    assign w_sum   = PW'(r_acc) + w_prod + (i_ctl.rnd ? RND : '0);
    assign w_shift = w_sum >>> DIG;

    assign w_dev = DW'(w_s_scaled) - DW'(r_base) + HALF;
    assign w_mag = r_di[SAMPLE_BITS] ? -r_di : r_di;

    // square: low digits leave through r_lo, high part stays narrow
    assign w_pp     = HW'(r_mag) * HW'(r_msh[DIG-1:0]);
    assign w_sq_sum = HW'(r_hi) + w_pp;

    assign w_full   = {r_hi, r_lo};
    assign o_square = w_full[2*SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_ctl.init) begin
            r_base <= w_in_scaled;
        end else if (i_ctl.upd) begin
            r_base <= r_base + r_acc[BW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_samp     <= i_sample;
            r_diff     <= DW'(w_in_scaled) - DW'(r_base);
            r_alpha_sh <= i_alpha;
            r_acc      <= '0;
        end
        if (i_ctl.mul) begin
            r_acc      <= w_shift[AW-1:0];
            r_alpha_sh <= r_alpha_sh >> DIG;
        end
        if (i_ctl.dev) begin
            r_di <= w_dev[DW-1:FRAC_BITS];
        end
        if (i_ctl.sqi) begin
            r_mag <= w_mag[SAMPLE_BITS-1:0];
            r_msh <= MW'(w_mag[SAMPLE_BITS-1:0]);
            r_hi  <= '0;
            r_lo  <= '0;
        end
        if (i_ctl.sq) begin
            r_hi  <= w_sq_sum[HW-1:DIG];
            r_lo  <= {w_sq_sum[DIG-1:0], r_lo[MW-1:DIG]};
            r_msh <= r_msh >> DIG;
        end
    end

endmodule

/* rtl/core/accel_shake_detector_core.sv */
// ----------------------------------------------------------------------------
// accel_shake_detector_core
// Three-axis shake detector: moving-average baselines, squared deviation
// energy against threshold squared, with a millisecond holdoff.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one sample transaction: three
//   axis values, a millisecond timestamp and a start request flag. Output
//   channel (o_valid/i_ready) returns one result per sample: shake and energy.
//   Configuration (i_cfg_valid/o_cfg_ready, always ready) writes threshold,
//   holdoff_ms or alpha by index; unknown indexes are ignored.
// Sequence:
//   A normal sample runs through the 4-bit digit-serial alpha multiply
//   (4 steps), the baseline update, the rounded deviation and the square
//   (ceil(SAMPLE_BITS/4) steps) in the three axis lanes, then the energy
//   is accumulated one axis at a time and compared; the next sample is
//   taken only once the block is back in idle.
//   A start request loads the baselines and goes to the compare; result is zero.
// Reset: synchronous active low; registers return to defaults, baselines
//   and last shake time clear.
// Stall: the result register holds while i_ready is low; a new sample is
//   still taken, and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module accel_shake_detector_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [SAMPLE_BITS-1:0]         i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0]         i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]         i_accel_z,
    input  logic [asd_pkg::TIME_BITS-1:0]         i_time_ms,
    input  logic                                  i_start_req,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_shake,
    output logic [asd_pkg::ENERGY_BITS-1:0]       o_energy,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [asd_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [asd_pkg::CFG_BITS-1:0]          i_cfg_data
);
    import asd_pkg::*;

    localparam int SQ_W     = 2 * SAMPLE_BITS;
    localparam int EAW      = (SQ_W + 2 > ENERGY_BITS) ? SQ_W + 2 : ENERGY_BITS;
    localparam int SQ_STEPS = (SAMPLE_BITS + DIG - 1) / DIG;
    localparam int CNT_MAX  = (SQ_STEPS > MUL_STEPS) ? SQ_STEPS : MUL_STEPS;
    localparam int CW       = $clog2(CNT_MAX);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_cnt, n_cnt;
    t_axis_ctl               w_ctl;

    logic [CFG_BITS-1:0]     r_threshold;
    logic [CFG_BITS-1:0]     r_holdoff;
    logic [CFG_BITS-1:0]     r_alpha;
    logic [TIME_BITS-1:0]    r_last;
    logic [TIME_BITS-1:0]    r_time;
    logic                    r_start;
    logic [2*CFG_BITS-1:0]   r_limit;
    logic [EAW-1:0]          r_energy;
    logic                    r_o_valid;
    logic                    r_o_shake;
    logic [ENERGY_BITS-1:0]  r_o_energy;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_done;
    logic                    w_sum;
    logic [SQ_W-1:0]         w_sq_x, w_sq_y, w_sq_z, w_sq_sel;
    logic [ENERGY_BITS-1:0]  w_energy_sat;
    logic [TIME_BITS-1:0]    w_elapsed;
    logic                    w_shake;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid & o_ready;
    assign w_out_free  = !r_o_valid | i_ready;

    assign o_valid  = r_o_valid;
    assign o_shake  = r_o_shake;
    assign o_energy = r_o_energy;

    asd_axis #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_sample(i_accel_x), .i_alpha(r_alpha), .o_square(w_sq_x)
    );

    asd_axis #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_sample(i_accel_y), .i_alpha(r_alpha), .o_square(w_sq_y)
    );

    asd_axis #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_sample(i_accel_z), .i_alpha(r_alpha), .o_square(w_sq_z)
    );

    always_comb begin
        case (r_cnt)
            CW'(0):  w_sq_sel = w_sq_x;
            CW'(1):  w_sq_sel = w_sq_y;
            default: w_sq_sel = w_sq_z;
        endcase
    end

    assign w_energy_sat = (r_energy > EAW'(ENERGY_MAX)) ? ENERGY_MAX
                                                        : r_energy[ENERGY_BITS-1:0];
    assign w_elapsed = r_time - r_last;
    assign w_shake   = !r_start && (w_energy_sat > ENERGY_BITS'(r_limit))
                       && (w_elapsed >= TIME_BITS'(r_holdoff));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_ctl   = '0;
        w_done  = 1'b0;
        w_sum   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    w_ctl.init = i_start_req;
                    w_ctl.load = !i_start_req;
                    n_cnt      = '0;
                    n_state    = i_start_req ? ST_CMP : ST_MUL;
                end
            end
            ST_MUL: begin
                w_ctl.mul = 1'b1;
                if (r_cnt == CW'(MUL_STEPS - 1)) begin
                    w_ctl.rnd = 1'b1;
                    n_cnt     = '0;
                    n_state   = ST_UPD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_UPD: begin
                w_ctl.upd = 1'b1;
                n_state   = ST_DEV;
            end
            ST_DEV: begin
                w_ctl.dev = 1'b1;
                n_state   = ST_SQI;
            end
            ST_SQI: begin
                w_ctl.sqi = 1'b1;
                n_state   = ST_SQ;
            end
            ST_SQ: begin
                w_ctl.sq = 1'b1;
                if (r_cnt == CW'(SQ_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_SUM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SUM: begin
                w_sum = 1'b1;
                if (r_cnt == CW'(NUM_AXES - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_CMP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_CMP: begin
                // hold here while the previous result is still unread
                if (w_out_free) begin
                    w_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_threshold <= THRESHOLD_RST;
            r_holdoff   <= HOLDOFF_RST;
            r_alpha     <= ALPHA_RST;
            r_last      <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    CFG_HOLDOFF:   r_holdoff   <= i_cfg_data;
                    CFG_ALPHA:     r_alpha     <= i_cfg_data;
                    default: ;
                endcase
            end
            // start request arms the holdoff so the next sample may fire
            if (w_in_acc && i_start_req) begin
                r_last <= i_time_ms - TIME_BITS'(r_holdoff);
            end else if (w_done && w_shake) begin
                r_last <= r_time;
            end
            if (w_done) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_time   <= i_time_ms;
            r_start  <= i_start_req;
            r_energy <= '0;
            r_limit  <= (2*CFG_BITS)'(r_threshold) * (2*CFG_BITS)'(r_threshold);
        end
        if (w_sum) begin
            r_energy <= r_energy + EAW'(w_sq_sel);
        end
        if (w_done) begin
            r_o_shake  <= w_shake;
            r_o_energy <= r_start ? '0 : w_energy_sat;
        end
    end

endmodule

/* bench/asd_shake_checker.sv */
// ----------------------------------------------------------------------------
// asd_shake_checker
// Watches the sample, result and configuration channels of the shake
// detector. Keeps its own copy of the baselines, the last shake time and the
// registers, predicts shake and energy for every accepted sample, and compares
// each accepted result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module asd_shake_checker #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0]        i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]        i_accel_z,
    input  logic [asd_pkg::TIME_BITS-1:0]        i_time_ms,
    input  logic                                 i_start_req,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic                                 i_shake,
    input  logic [asd_pkg::ENERGY_BITS-1:0]      i_energy,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [asd_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [asd_pkg::CFG_BITS-1:0]         i_cfg_data,
    output int                                   o_pending,
    output int                                   o_fail_count
);
    import asd_pkg::*;

    typedef struct packed {
        logic                   shake;
        logic [ENERGY_BITS-1:0] energy;
    } t_shake_result;

    localparam logic signed [63:0] ALPHA_HALF = 64'sd1 <<< (ALPHA_BITS - 1);
    localparam logic signed [63:0] FRAC_HALF  = 64'sd1 <<< (FRAC_BITS - 1);

    logic [CFG_BITS-1:0]  thr_reg;
    logic [CFG_BITS-1:0]  holdoff_reg;
    logic [CFG_BITS-1:0]  alpha_reg;
    logic signed [63:0]   baseline [NUM_AXES];
    logic [TIME_BITS-1:0] shake_time;
    t_shake_result        expected_results [$];
    t_shake_result        oldest;
    t_shake_result        predicted;
    int                   mismatches = 0;
    int                   result_count = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // moves one baseline toward the sample and returns its squared deviation
    task automatic step_axis(input  logic signed [SAMPLE_BITS-1:0] smp,
                             inout  logic signed [63:0]            base,
                             output logic [63:0]                   dev_sq);
        logic signed [63:0] scaled;
        logic signed [63:0] diff;
        logic signed [63:0] dev;
        scaled = 64'(smp);
        scaled = scaled <<< FRAC_BITS;
        diff   = scaled - base;
        // update rounded half up, arithmetic shift gives the floor
        base   = base + ((diff * $signed(64'(alpha_reg)) + ALPHA_HALF) >>> ALPHA_BITS);
        dev    = (scaled - base + FRAC_HALF) >>> FRAC_BITS;
        if (dev < 0) begin
            dev = -dev;
        end
        dev_sq = dev * dev;
    endtask

    task automatic predict_sample(input  logic signed [SAMPLE_BITS-1:0] ax, ay, az,
                                  input  logic [TIME_BITS-1:0]          stamp,
                                  input  logic                          start,
                                  output t_shake_result                 res);
        logic signed [SAMPLE_BITS-1:0] smp [NUM_AXES];
        logic signed [63:0]            lvl;
        logic [63:0]                   dev_sq;
        logic [63:0]                   sum;
        logic [63:0]                   limit;
        logic [TIME_BITS-1:0]          elapsed;
        smp[0] = ax;
        smp[1] = ay;
        smp[2] = az;
        res = '0;
        sum = '0;
        if (start) begin
            // baselines jump to the sample, holdoff counts as already elapsed
            for (int a = 0; a < NUM_AXES; a++) begin
                lvl         = 64'(smp[a]);
                baseline[a] = lvl <<< FRAC_BITS;
            end
            shake_time = stamp - TIME_BITS'(holdoff_reg);
        end else begin
            for (int a = 0; a < NUM_AXES; a++) begin
                lvl = baseline[a];
                step_axis(smp[a], lvl, dev_sq);
                baseline[a] = lvl;
                sum = sum + dev_sq;
            end
            if (sum > 64'(ENERGY_MAX)) begin
                sum = 64'(ENERGY_MAX);
            end
            limit   = 64'(thr_reg) * 64'(thr_reg);
            elapsed = stamp - shake_time;
            if (sum > limit && elapsed >= TIME_BITS'(holdoff_reg)) begin
                shake_time = stamp;
                res.shake  = 1'b1;
            end
            res.energy = sum[ENERGY_BITS-1:0];
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_reg     = THRESHOLD_RST;
            holdoff_reg = HOLDOFF_RST;
            alpha_reg   = ALPHA_RST;
            for (int a = 0; a < NUM_AXES; a++) begin
                baseline[a] = '0;
            end
            shake_time = '0;
            expected_results.delete();
        end else begin
            // results first, so a stray result is never matched to a sample
            // accepted at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d: shake %0b energy %0d",
                                              result_count, i_shake, i_energy));
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_shake !== oldest.shake) begin
                        report_mismatch($sformatf("result %0d shake %0b, expected %0b",
                                                  result_count, i_shake, oldest.shake));
                    end
                    if (i_energy !== oldest.energy) begin
                        report_mismatch($sformatf("result %0d energy %0d, expected %0d",
                                                  result_count, i_energy, oldest.energy));
                    end
                end
                result_count++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: thr_reg     = i_cfg_data;
                    CFG_HOLDOFF:   holdoff_reg = i_cfg_data;
                    CFG_ALPHA:     alpha_reg   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_sample(i_accel_x, i_accel_y, i_accel_z, i_time_ms, i_start_req,
                               predicted);
                expected_results.push_back(predicted);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

/* bench/accel_shake_detector_core_tb.sv */
// ----------------------------------------------------------------------------
// accel_shake_detector_core_tb
// Drives sample transactions into the shake detector: a directed opening on
// extremes, holdoff edges, timestamp wrap and the threshold boundary, then
// randomized sessions (start transaction followed by jittered samples with
// spikes) mixed with noise, under several register settings. Both channels
// idle at random. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module accel_shake_detector_core_tb;
    import asd_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SMP_MAX     = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SMP_MIN     = -(1 << (SAMPLE_BITS - 1));
    localparam int IDLE_PCT    = 18;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_accel_x   = '0;
    logic signed [SAMPLE_BITS-1:0] i_accel_y   = '0;
    logic signed [SAMPLE_BITS-1:0] i_accel_z   = '0;
    logic [TIME_BITS-1:0]          i_time_ms   = '0;
    logic                          i_start_req = 1'b0;
    logic                          o_valid;
    logic                          i_ready     = 1'b0;
    logic                          o_shake;
    logic [ENERGY_BITS-1:0]        o_energy;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]       i_cfg_index = '0;
    logic [CFG_BITS-1:0]           i_cfg_data  = '0;

    logic                          no_idle     = 1'b0;
    logic [TIME_BITS-1:0]          now_ms      = '0;
    int                            results_due;
    int                            mismatch_total;
    int                            cycle_count = 0;

    accel_shake_detector_core #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_time_ms  (i_time_ms),
        .i_start_req(i_start_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_shake    (o_shake),
        .o_energy   (o_energy),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    asd_shake_checker #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_time_ms   (i_time_ms),
        .i_start_req (i_start_req),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_shake     (o_shake),
        .i_energy    (o_energy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (results_due),
        .o_fail_count(mismatch_total)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // valid stays high between back-to-back transactions, drops only in a gap
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] ax, ay, az,
                               input logic [TIME_BITS-1:0]          stamp,
                               input logic                          start);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_accel_x   <= ax;
        i_accel_y   <= ay;
        i_accel_z   <= az;
        i_time_ms   <= stamp;
        i_start_req <= start;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
    endtask

    // writes all three registers plus one unmapped index, block idle
    task automatic write_config(input logic [CFG_BITS-1:0] thr, hold, coef);
        drain_results();
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            case (k)
                0: begin
                    i_cfg_index <= CFG_THRESHOLD;
                    i_cfg_data  <= thr;
                end
                1: begin
                    i_cfg_index <= CFG_HOLDOFF;
                    i_cfg_data  <= hold;
                end
                2: begin
                    i_cfg_index <= CFG_ALPHA;
                    i_cfg_data  <= coef;
                end
                default: begin
                    i_cfg_index <= CFG_UNMAPPED;
                    i_cfg_data  <= CFG_BITS'($urandom);
                end
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] jitter_sample(
            input logic signed [SAMPLE_BITS-1:0] center);
        int pick;
        int v;
        pick = $urandom_range(99);
        v    = int'(center);
        if (pick < 12) begin
            // spike in either direction
            if (pick[0]) begin
                v = v + int'($urandom_range(300, 40000));
            end else begin
                v = v - int'($urandom_range(300, 40000));
            end
        end else if (pick < 15) begin
            v = pick[0] ? SMP_MAX : SMP_MIN;
        end else begin
            v = v + int'($urandom_range(80)) - 40;
        end
        if (v > SMP_MAX) v = SMP_MAX;
        if (v < SMP_MIN) v = SMP_MIN;
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic run_shake_sessions(input int n_items);
        int                            sent;
        int                            len;
        int                            pick;
        logic signed [SAMPLE_BITS-1:0] cx, cy, cz;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                // start transaction, then a run of samples around one pose
                cx = SAMPLE_BITS'($urandom);
                cy = SAMPLE_BITS'($urandom);
                cz = SAMPLE_BITS'($urandom);
                if ($urandom_range(99) < 4) begin
                    now_ms = 32'hFFFF_FFFF - $urandom_range(3000);
                end else begin
                    now_ms = now_ms + $urandom_range(2000);
                end
                send_sample(cx, cy, cz, now_ms, 1'b1);
                len = $urandom_range(3, 30);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(99);
                    // picks 85 to 94 repeat the timestamp
                    if (pick < 70) begin
                        now_ms = now_ms + $urandom_range(1, 150);
                    end else if (pick < 85) begin
                        now_ms = now_ms + $urandom_range(150, 1200);
                    end else if (pick >= 95) begin
                        now_ms = now_ms + $urandom_range(70000);
                    end
                    send_sample(jitter_sample(cx), jitter_sample(cy), jitter_sample(cz),
                                now_ms, 1'b0);
                end
                sent += len + 1;
            end else begin
                // noise, stray start transactions included
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(1) == 1) begin
                        now_ms = $urandom;
                    end else begin
                        now_ms = now_ms + $urandom_range(400);
                    end
                    send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                                SAMPLE_BITS'($urandom), now_ms,
                                $urandom_range(99) < 15);
                end
                sent += len;
            end
            if ($urandom_range(99) < 5) begin
                drain_results();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers, baselines still zero
        send_sample(0, 0, 0, 32'd0, 1'b0);
        send_sample(SAMPLE_BITS'(SMP_MAX), SAMPLE_BITS'(SMP_MAX), SAMPLE_BITS'(SMP_MAX),
                    32'd1000, 1'b0);
        send_sample(SAMPLE_BITS'(SMP_MIN), SAMPLE_BITS'(SMP_MIN), SAMPLE_BITS'(SMP_MIN),
                    32'd1100, 1'b0);
        // start transaction arms the holdoff behind time zero
        send_sample(SAMPLE_BITS'(SMP_MIN), SAMPLE_BITS'(SMP_MAX), 0, 32'd5, 1'b1);
        send_sample(SAMPLE_BITS'(SMP_MIN), SAMPLE_BITS'(SMP_MAX), 0, 32'd6, 1'b0);
        send_sample(SAMPLE_BITS'(SMP_MAX), SAMPLE_BITS'(SMP_MIN), 0, 32'd7, 1'b0);
        send_sample(SAMPLE_BITS'(SMP_MAX), SAMPLE_BITS'(SMP_MIN), 0, 32'd300, 1'b0);
        // one short of the holdoff, then exactly on it
        send_sample(SAMPLE_BITS'(SMP_MIN), SAMPLE_BITS'(SMP_MAX), 0, 32'd506, 1'b0);
        send_sample(SAMPLE_BITS'(SMP_MIN), SAMPLE_BITS'(SMP_MAX), 0, 32'd507, 1'b0);
        // timestamp wraps between start and shake
        send_sample(100, -100, 5, 32'hFFFF_FF00, 1'b1);
        send_sample(100, -100, 5, 32'h0000_0010, 1'b0);
        send_sample(2000, -100, 5, 32'h0000_0020, 1'b0);
        send_sample(2000, -100, 5, 32'h0000_0030, 1'b0);
        // rounded deviation lands on the threshold, then one above
        send_sample(0, 0, 0, 32'd20000, 1'b1);
        send_sample(612, 0, 0, 32'd20600, 1'b0);
        send_sample(0, 0, 0, 32'd21000, 1'b1);
        send_sample(613, 0, 0, 32'd21600, 1'b0);
        now_ms = 32'd22000;

        write_config(16'd0, 16'd0, 16'hFFFF);
        run_shake_sessions(140);

        write_config(16'hFFFF, 16'hFFFF, 16'd0);
        no_idle <= 1'b1;
        run_shake_sessions(120);

        write_config(THRESHOLD_RST, HOLDOFF_RST, ALPHA_RST);
        no_idle <= 1'b0;
        run_shake_sessions(180);

        write_config(CFG_BITS'($urandom_range(50, 2000)), CFG_BITS'($urandom_range(1500)),
                     CFG_BITS'($urandom_range(200, 20000)));
        run_shake_sessions(160);

        write_config(CFG_BITS'($urandom), CFG_BITS'($urandom), CFG_BITS'($urandom));
        run_shake_sessions(150);

        write_config(16'hFFFF, 16'd0, 16'd1);
        run_shake_sessions(100);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_total == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
